/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for concurrent assertions clocked by clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, clocked on clk, off during reset.
`define BMH_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bmh: property violated");

// A word offered but not taken stays offered and unchanged.
`define BMH_ASSERT_HOLD(lbl, vld, rdy, sig) \
	`BMH_ASSERT(lbl, (vld && !rdy) |=> (vld && $stable(sig)))

`endif

/* rtl/core/bmh_pkg.sv */
// ----------------------------------------------------------------------------
// Heap queue package
// Sizes, entry and status types, and the control structs shared between the
// sequencer and the top level.
// ----------------------------------------------------------------------------
package bmh_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHW      = IDX_W + 2;
	localparam int TOTAL_W  = 11;
	localparam int VAL_W    = 32;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] data;
		logic signed [VAL_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr_a;
		logic [IDX_W-1:0] raddr_b;
	} mem_req_t;

	typedef struct packed {
		logic                    valid;
		status_t                 status;
		logic signed [VAL_W-1:0] data;
		logic signed [VAL_W-1:0] prio;
		logic [TOTAL_W-1:0]      total;
	} result_t;

	function automatic logic prio_less(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		return a < b;
	endfunction

	// Low bits of the count as reported on the result word.
	function automatic logic [TOTAL_W-1:0] total_of(input logic [CNT_W-1:0] c);
		logic [CNT_W+TOTAL_W-1:0] w;
		w = {{TOTAL_W{1'b0}}, c};
		return w[TOTAL_W-1:0];
	endfunction

endpackage

/* rtl/core/bmh_if.sv */
// ----------------------------------------------------------------------------
// Heap queue channels
// Request channel (operation and pair) and response channel (status, removed
// pair and count), each a valid/ready word.
// ----------------------------------------------------------------------------
interface bmh_req_if;
	import bmh_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    mode;
	logic signed [VAL_W-1:0] item_data;
	logic signed [VAL_W-1:0] item_priority;

	modport source (output valid, output mode, output item_data, output item_priority,
		input ready);
	modport sink (input valid, input mode, input item_data, input item_priority,
		output ready);
endinterface

interface bmh_rsp_if;
	import bmh_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] removed_data;
	logic signed [VAL_W-1:0] removed_priority;
	logic [TOTAL_W-1:0]      entry_total;

	modport source (output valid, output status, output removed_data,
		output removed_priority, output entry_total, input ready);
	modport sink (input valid, input status, input removed_data,
		input removed_priority, input entry_total, output ready);
endinterface

/* rtl/core/binary_min_heap_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Holds up to CAPACITY (data, priority) pairs in one two-read-port RAM with
// registered read. Each request word is an insert or a remove of the entry of
// smallest priority, and gives exactly one response word with status, the
// removed pair (zero unless removed) and the count afterwards. One request is
// worked at a time: an insert climbs one level per parent read and compare,
// a remove lets the last entry sink one level per child read and compare,
// and the result waits in the done state until the output register is free.
// Each level costs one registered RAM read, which precedes the compare and
// write-back. No clearing pass follows reset: only entries below the count
// are ever used. A new request is taken while the previous response still
// waits in the output register.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_unit (
	input logic      clk,
	input logic      arst_n,
	bmh_req_if.sink  req,
	bmh_rsp_if.source rsp
);
	import bmh_pkg::*;

	mem_req_t mem;
	result_t  res;
	entry_t   rd_a;
	entry_t   rd_b;
	logic     out_free;

	logic                    rsp_valid_q;
	status_t                 rsp_status_q;
	logic signed [VAL_W-1:0] rsp_data_q;
	logic signed [VAL_W-1:0] rsp_prio_q;
	logic [TOTAL_W-1:0]      rsp_total_q;

	bmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_mode  (req.mode),
		.req_data  (req.item_data),
		.req_prio  (req.item_priority),
		.out_free  (out_free),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.mem       (mem),
		.res       (res)
	);

	bmh_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (mem.we),
		.waddr   (mem.waddr),
		.wdata   (mem.wdata),
		.raddr_a (mem.raddr_a),
		.raddr_b (mem.raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Output register: loads when empty or being drained.
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			rsp_status_q <= res.status;
			rsp_data_q   <= res.data;
			rsp_prio_q   <= res.prio;
			rsp_total_q  <= res.total;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.removed_data     = rsp_data_q;
	assign rsp.removed_priority = rsp_prio_q;
	assign rsp.entry_total      = rsp_total_q;
endmodule

/* rtl/core/bmh_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bmh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;
endmodule

/* rtl/core/bmh_ctrl.sv */
// ----------------------------------------------------------------------------
// Heap sequencer
// Holds the entry count and the moving entry, walks the heap one level per
// read/compare pair, and writes entries back as they shift.
// ----------------------------------------------------------------------------
module bmh_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic                            req_mode,
	input  logic signed [bmh_pkg::VAL_W-1:0] req_data,
	input  logic signed [bmh_pkg::VAL_W-1:0] req_prio,
	input  logic                            out_free,
	input  bmh_pkg::entry_t                 rd_a,
	input  bmh_pkg::entry_t                 rd_b,
	output bmh_pkg::mem_req_t               mem,
	output bmh_pkg::result_t                res
);
	import bmh_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_INS_RD  = 7'b0000010,
		S_INS_CMP = 7'b0000100,
		S_DEL_RD  = 7'b0001000,
		S_DN_RD   = 7'b0010000,
		S_DN_CMP  = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [IDX_W-1:0]        pos_q, pos_d;
	entry_t                  mov_q, mov_d;
	status_t                 status_q, status_d;
	logic signed [VAL_W-1:0] rdata_q, rdata_d;
	logic signed [VAL_W-1:0] rprio_q, rprio_d;

	logic [CNT_W-1:0] last_w;
	logic [IDX_W-1:0] parent;
	logic [CHW-1:0]   left_w;
	logic [CHW-1:0]   right_w;
	logic             full;
	logic             l_sel;
	logic             r_sel;
	logic signed [VAL_W-1:0] best_prio;

	assign full    = cnt_q >= CNT_W'(CAPACITY);
	assign last_w  = cnt_q - CNT_W'(1);
	assign parent  = (pos_q - IDX_W'(1)) >> 1;
	assign left_w  = (CHW'(pos_q) << 1) + CHW'(1);
	assign right_w = (CHW'(pos_q) << 1) + CHW'(2);

	// Left child wins on strictly smaller, right child must beat the winner.
	assign l_sel     = (left_w < CHW'(cnt_q)) && prio_less(rd_a.prio, mov_q.prio);
	assign best_prio = l_sel ? rd_a.prio : mov_q.prio;
	assign r_sel     = (right_w < CHW'(cnt_q)) && prio_less(rd_b.prio, best_prio);

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pos_d    = pos_q;
		mov_d    = mov_q;
		status_d = status_q;
		rdata_d  = rdata_q;
		rprio_d  = rprio_q;
		mem      = '0;
		case (state_q)
			S_IDLE: begin
				// Root and last entry are fetched ahead of any remove.
				mem.raddr_a = '0;
				mem.raddr_b = last_w[IDX_W-1:0];
				if (req_valid) begin
					rdata_d = '0;
					rprio_d = '0;
					if (req_mode == MODE_INSERT) begin
						if (full) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else begin
							status_d = ST_INSERTED;
							mov_d    = '{data: req_data, prio: req_prio};
							pos_d    = cnt_q[IDX_W-1:0];
							cnt_d    = cnt_q + CNT_W'(1);
							state_d  = S_INS_RD;
						end
					end else begin
						if (cnt_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							status_d = ST_REMOVED;
							cnt_d    = last_w;
							state_d  = S_DEL_RD;
						end
					end
				end
			end
			S_INS_RD: begin
				if (pos_q == '0) begin
					mem.we    = 1'b1;
					mem.waddr = pos_q;
					mem.wdata = mov_q;
					state_d   = S_DONE;
				end else begin
					mem.raddr_a = parent;
					state_d     = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				mem.we    = 1'b1;
				mem.waddr = pos_q;
				if (prio_less(mov_q.prio, rd_a.prio)) begin
					mem.wdata = rd_a;
					pos_d     = parent;
					state_d   = S_INS_RD;
				end else begin
					mem.wdata = mov_q;
					state_d   = S_DONE;
				end
			end
			S_DEL_RD: begin
				rdata_d = rd_a.data;
				rprio_d = rd_a.prio;
				mov_d   = rd_b;
				pos_d   = '0;
				state_d = (cnt_q == '0) ? S_DONE : S_DN_RD;
			end
			S_DN_RD: begin
				mem.raddr_a = left_w[IDX_W-1:0];
				mem.raddr_b = right_w[IDX_W-1:0];
				state_d     = S_DN_CMP;
			end
			S_DN_CMP: begin
				mem.we    = 1'b1;
				mem.waddr = pos_q;
				if (r_sel) begin
					mem.wdata = rd_b;
					pos_d     = right_w[IDX_W-1:0];
					state_d   = S_DN_RD;
				end else if (l_sel) begin
					mem.wdata = rd_a;
					pos_d     = left_w[IDX_W-1:0];
					state_d   = S_DN_RD;
				end else begin
					mem.wdata = mov_q;
					state_d   = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		mov_q    <= mov_d;
		status_q <= status_d;
		rdata_q  <= rdata_d;
		rprio_q  <= rprio_d;
	end

	assign res.valid  = (state_q == S_DONE) && out_free;
	assign res.status = status_q;
	assign res.data   = rdata_q;
	assign res.prio   = rprio_q;
	assign res.total  = total_of(cnt_q);
endmodule

/* rtl/core/bmh_checker.sv */
// ----------------------------------------------------------------------------
// Heap queue checker
// Watches the response channel of the heap queue for held words and for
// status and payload combinations that cannot occur.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmh_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [1:0]                          rsp_status,
	input logic signed [bmh_pkg::VAL_W-1:0]    rsp_data,
	input logic signed [bmh_pkg::VAL_W-1:0]    rsp_prio,
	input logic [bmh_pkg::TOTAL_W-1:0]         rsp_total
);
	import bmh_pkg::*;

	logic [2+2*VAL_W+TOTAL_W-1:0] rsp_word;
	logic                         pair_zero;
	logic [TOTAL_W-1:0]           full_total;

	assign rsp_word   = {rsp_status, rsp_data, rsp_prio, rsp_total};
	assign pair_zero  = (rsp_data == '0) && (rsp_prio == '0);
	assign full_total = total_of(CNT_W'(CAPACITY));

	`BMH_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, rsp_word)

	// Only a successful remove carries a pair.
	`BMH_ASSERT(a_pair_zero, (rsp_valid && rsp_status != ST_REMOVED) |-> pair_zero)

	`BMH_ASSERT(a_empty_total, (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_total == '0))

	`BMH_ASSERT(a_full_total, (rsp_valid && rsp_status == ST_FULL) |-> (rsp_total == full_total))
endmodule

bind binary_min_heap_priority_queue_unit bmh_checker u_bmh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_data   (rsp.removed_data),
	.rsp_prio   (rsp.removed_priority),
	.rsp_total  (rsp.entry_total)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heap queue testbench
// Drives insert and remove words into the min-heap queue, keeps its own heap
// to predict each response word, and checks every response field in order.
// A short table of directed words comes first, then random traffic under
// three idling patterns, ending with a fill to capacity and rejected inserts.
// ----------------------------------------------------------------------------
module tb;
	import bmh_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 40;

	typedef struct packed {
		status_t                 st;
		logic signed [VAL_W-1:0] data;
		logic signed [VAL_W-1:0] prio;
		logic [TOTAL_W-1:0]      total;
	} rsp_word_t;

	typedef struct packed {
		logic             mode;
		logic [VAL_W-1:0] data;
		logic [VAL_W-1:0] prio;
		logic             typed;
		rsp_word_t        rsp;
	} stim_row_t;

	logic clk;
	logic arst_n;

	bmh_req_if req_ch ();
	bmh_rsp_if rsp_ch ();

	binary_min_heap_priority_queue_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow heap and the responses it has predicted but not yet seen.
	entry_t    heap_mem [CAPACITY];
	int        heap_count;
	rsp_word_t pending_rsp_q [$];

	int fail_count;
	int stall_cycles = 0;
	int send_idle_pct;
	int recv_idle_pct;

	// Rows with typed set carry a response that is obvious by inspection; the
	// rest are left to the shadow heap (ties and reordering after removal).
	stim_row_t dir_rows [25] = '{
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{ST_EMPTY, 32'h0, 32'h0, 11'd0}},
		'{MODE_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd1}},
		'{MODE_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd2}},
		'{MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd3}},
		'{MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd4}},
		'{MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{ST_REMOVED, 32'h8000_0000, 32'h8000_0000, 11'd3}},
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{ST_REMOVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2}},
		'{MODE_INSERT, 32'd11, 32'h0000_0000, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd3}},
		'{MODE_INSERT, 32'd12, 32'h0000_0000, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd4}},
		'{MODE_INSERT, 32'd13, 32'hFFFF_FFFB, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd5}},
		'{MODE_INSERT, 32'd14, 32'h7FFF_FFFF, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd6}},
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{ST_REMOVED, 32'd13, 32'hFFFF_FFFB, 11'd5}},
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{MODE_REMOVE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
		'{MODE_REMOVE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{ST_EMPTY, 32'h0, 32'h0, 11'd0}},
		'{MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{ST_EMPTY, 32'h0, 32'h0, 11'd0}},
		'{MODE_INSERT, 32'hA5A5_A5A5, 32'h0000_0001, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd1}},
		'{MODE_INSERT, 32'h5A5A_5A5A, 32'hFFFF_FFFE, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd2}},
		'{MODE_INSERT, 32'd3, 32'h0000_0002, 1'b1,
			'{ST_INSERTED, 32'h0, 32'h0, 11'd3}},
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{ST_REMOVED, 32'h5A5A_5A5A, 32'hFFFF_FFFE, 11'd2}},
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Applies one operation to the shadow heap and returns the response word.
	function automatic rsp_word_t apply_heap_op(input logic m,
		input logic signed [VAL_W-1:0] d, input logic signed [VAL_W-1:0] p);
		rsp_word_t res;
		entry_t    tmp;
		int        i;
		int        par;
		int        pos;
		int        lft;
		int        rgt;
		int        best;
		logic      done;
		res = '0;
		if (m == MODE_INSERT) begin
			if (heap_count >= CAPACITY) begin
				res.st = ST_FULL;
			end else begin
				i = heap_count;
				heap_count++;
				done = 1'b0;
				while (i != 0 && !done) begin
					par = (i - 1) / 2;
					if (p < heap_mem[par].prio) begin
						heap_mem[i] = heap_mem[par];
						i = par;
					end else begin
						done = 1'b1;
					end
				end
				heap_mem[i].data = d;
				heap_mem[i].prio = p;
				res.st = ST_INSERTED;
			end
		end else if (heap_count == 0) begin
			res.st = ST_EMPTY;
		end else begin
			res.st = ST_REMOVED;
			res.data = heap_mem[0].data;
			res.prio = heap_mem[0].prio;
			heap_count--;
			heap_mem[0] = heap_mem[heap_count];
			pos = 0;
			done = 1'b0;
			while (!done) begin
				lft = 2 * pos + 1;
				rgt = lft + 1;
				best = pos;
				if (lft < heap_count && heap_mem[lft].prio < heap_mem[pos].prio)
					best = lft;
				if (rgt < heap_count && heap_mem[rgt].prio < heap_mem[best].prio)
					best = rgt;
				if (best == pos) begin
					done = 1'b1;
				end else begin
					tmp = heap_mem[pos];
					heap_mem[pos] = heap_mem[best];
					heap_mem[best] = tmp;
					pos = best;
				end
			end
		end
		res.total = heap_count[TOTAL_W-1:0];
		return res;
	endfunction

	function automatic logic [VAL_W-1:0] rand_prio();
		logic [VAL_W-1:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			// A narrow band around zero gives many equal priorities.
			1, 2, 3: v = $urandom_range(16) - 8;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// Offers one request word, holding it until taken, then records what the
	// response must be.
	task automatic send_op(input logic m, input logic [VAL_W-1:0] d,
		input logic [VAL_W-1:0] p, input logic typed, input rsp_word_t typed_rsp);
		rsp_word_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.mode          <= m;
		req_ch.item_data     <= d;
		req_ch.item_priority <= p;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pred = apply_heap_op(m, d, p);
		pending_rsp_q.push_back(typed ? typed_rsp : pred);
	endtask

	task automatic send_random(input logic m);
		send_op(m, $urandom(), rand_prio(), 1'b0, '0);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsp_q.size() != 0);
	endtask

	// Random traffic that wanders between small fill levels, with removes
	// favoured while the level target is zero, so that some removes find it empty.
	task automatic run_mixed(input int n_items);
		int   k;
		int   goal;
		int   seg_left;
		logic m;
		goal = 0;
		seg_left = 0;
		for (k = 0; k < n_items; k++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(80, 20);
				goal = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 1);
			end
			seg_left--;
			if ($urandom_range(63) == 0)
				wait_drained();
			if ($urandom_range(19) == 0)
				m = 1'($urandom_range(1));
			else if (heap_count < goal)
				m = ($urandom_range(99) < 75) ? MODE_INSERT : MODE_REMOVE;
			else
				m = ($urandom_range(99) < 25) ? MODE_INSERT : MODE_REMOVE;
			send_random(m);
		end
	endtask

	// Fills the queue to capacity, works around the full mark so that some
	// inserts are rejected, then drains part of it again.
	task automatic run_fill();
		int k;
		while (heap_count < CAPACITY)
			send_random(($urandom_range(99) < 96) ? MODE_INSERT : MODE_REMOVE);
		for (k = 0; k < 40; k++)
			send_random(($urandom_range(99) < 70) ? MODE_INSERT : MODE_REMOVE);
		for (k = 0; k < 60; k++)
			send_random(($urandom_range(99) < 80) ? MODE_REMOVE : MODE_INSERT);
	endtask

	task automatic check_field(input string name, input logic [VAL_W-1:0] want,
		input logic [VAL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_response();
		rsp_word_t want;
		if (pending_rsp_q.size() == 0) begin
			$display("%0t: response word with none expected: status %h total %0d", $time,
				rsp_ch.status, rsp_ch.entry_total);
			fail_count++;
		end else begin
			want = pending_rsp_q.pop_front();
			check_field("status", VAL_W'(want.st), VAL_W'(rsp_ch.status));
			check_field("removed_data", want.data, rsp_ch.removed_data);
			check_field("removed_priority", want.prio, rsp_ch.removed_priority);
			check_field("entry_total", VAL_W'(want.total), VAL_W'(rsp_ch.entry_total));
		end
	endtask

	// Response side: take a word when one is offered, then choose ready.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				check_response();
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, stall_cycles);
			$display("** binary_min_heap_priority_queue_unit: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.mode          = MODE_INSERT;
		req_ch.item_data     = '0;
		req_ch.item_priority = '0;
		heap_count           = 0;
		fail_count           = 0;
		send_idle_pct        = 17;
		recv_idle_pct        = 54;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r])
			send_op(dir_rows[r].mode, dir_rows[r].data, dir_rows[r].prio,
				dir_rows[r].typed, dir_rows[r].rsp);
		wait_drained();
		run_mixed(200);
		wait_drained();

		send_idle_pct = 54;
		recv_idle_pct = 17;
		run_mixed(200);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_fill();
		wait_drained();
		repeat (SETTLE_TICKS) @(posedge clk);

		if (fail_count == 0) begin
			$display("** binary_min_heap_priority_queue_unit: PASSED **");
		end else begin
			$display("** binary_min_heap_priority_queue_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bmh_pkg.sv
rtl/core/bmh_if.sv
rtl/core/bmh_ram.sv
rtl/core/bmh_ctrl.sv
rtl/core/binary_min_heap_priority_queue_unit.sv
rtl/core/bmh_checker.sv
tb/sv/tb.sv
